// ===== rtl/pcws_pkg.sv =====
// ----------------------------------------------------------------------------
// pcws_pkg
// Types and codes shared by the padded 2D window sum block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pcws_pkg;

  localparam int MAX_DIM      = 64;
  localparam int MAX_K        = 5;
  localparam int SAMPLE_WIDTH = 16;
  localparam int INDEX_WIDTH  = 7;
  localparam int SUM_WIDTH    = 40;
  localparam int CFG_WIDTH    = 7;
  localparam int CFG_IDX_W    = 3;

  typedef enum logic [1:0] {
    CMD_TAP     = 2'd0,
    CMD_PIXEL   = 2'd1,
    CMD_COMPUTE = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_ROWS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_COLS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_PADDING = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_PADDING = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLS  = 3'd5;

  typedef struct packed {
    cmd_t                            command;
    logic [INDEX_WIDTH-1:0]          row_index;
    logic [INDEX_WIDTH-1:0]          col_index;
    logic signed [SAMPLE_WIDTH-1:0]  sample_value;
  } req_t;

  typedef struct packed {
    logic signed [SUM_WIDTH-1:0] conv_sum;
    logic                        position_error;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic issue;
    logic acc_clear;
    logic load_err;
    logic load_sum;
  } ctrl_t;

endpackage

// ===== rtl/padded_conv2d_window_sum.sv =====
// ----------------------------------------------------------------------------
// padded_conv2d_window_sum
// Writes: tap and pixel writes are taken one per cycle while no compute
// request is in progress. A compute request outside the output returns its
// error result in the cycle after it is taken. A valid one walks the kernel
// taps through the read, product and accumulate registers and returns its
// sum from the output register; all requests stall meanwhile, since the
// single multiply-accumulate walks the taps against the frame's one read port.
// Reset: rst clears control and loads the register defaults; stores are not
// cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module padded_conv2d_window_sum (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [pcws_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pcws_pkg::CFG_WIDTH-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  pcws_pkg::req_t                    in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output pcws_pkg::rsp_t                    out_data
);

  import pcws_pkg::*;

  localparam int DW0 = $clog2(MAX_DIM + 1);
  localparam int DW  = (DW0 > INDEX_WIDTH) ? DW0 : INDEX_WIDTH;
  localparam int IW  = DW + 3;
  localparam int YW  = $clog2(MAX_DIM);
  localparam int FAW = $clog2(MAX_DIM * MAX_DIM);
  localparam int KW  = $clog2(MAX_K + 1);
  localparam int KIW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int KAW = (MAX_K > 1) ? $clog2(MAX_K * MAX_K) : 1;
  localparam int PW  = 2 * SAMPLE_WIDTH;

  logic [2:0]                  kernel_rows;
  logic [2:0]                  kernel_cols;
  logic [2:0]                  row_padding;
  logic [2:0]                  col_padding;
  logic [INDEX_WIDTH-1:0]      image_rows;
  logic [INDEX_WIDTH-1:0]      image_cols;

  logic signed [SAMPLE_WIDTH-1:0] frame_store [MAX_DIM*MAX_DIM];
  logic signed [SAMPLE_WIDTH-1:0] kernel_store [MAX_K*MAX_K];

  state_t state;
  state_t state_next;
  ctrl_t  ctrl;

  logic                         accept;
  logic                         out_free;
  logic                         pos_err;
  logic [KW-1:0]                kr;
  logic [KW-1:0]                kc;
  logic [DW-1:0]                ir;
  logic [DW-1:0]                ic;
  logic signed [IW-1:0]         req_row;
  logic signed [IW-1:0]         req_col;
  logic signed [IW-1:0]         out_rows;
  logic signed [IW-1:0]         out_cols;

  logic signed [IW-1:0]         orow;
  logic signed [IW-1:0]         ocol;
  logic [KIW-1:0]               tap_r;
  logic [KIW-1:0]               tap_c;
  logic                         last_tap;
  logic signed [IW-1:0]         pix_y;
  logic signed [IW-1:0]         pix_x;
  logic                         pix_inb;
  logic [FAW-1:0]               frame_raddr;
  logic [KAW-1:0]               kern_raddr;

  logic                         rd_valid;
  logic                         rd_inb;
  logic signed [SAMPLE_WIDTH-1:0] frame_rd;
  logic signed [SAMPLE_WIDTH-1:0] kern_rd;
  logic                         prod_valid;
  logic signed [PW-1:0]         prod;
  logic signed [SUM_WIDTH-1:0]  acc;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Clamp sizes to the store limits
  always_comb begin
    if (kernel_rows == '0) begin
      kr = KW'(1);
    end else if (int'(kernel_rows) > MAX_K) begin
      kr = KW'(MAX_K);
    end else begin
      kr = KW'(kernel_rows);
    end
    if (kernel_cols == '0) begin
      kc = KW'(1);
    end else if (int'(kernel_cols) > MAX_K) begin
      kc = KW'(MAX_K);
    end else begin
      kc = KW'(kernel_cols);
    end
    if (image_rows == '0) begin
      ir = DW'(1);
    end else if (int'(image_rows) > MAX_DIM) begin
      ir = DW'(MAX_DIM);
    end else begin
      ir = DW'(image_rows);
    end
    if (image_cols == '0) begin
      ic = DW'(1);
    end else if (int'(image_cols) > MAX_DIM) begin
      ic = DW'(MAX_DIM);
    end else begin
      ic = DW'(image_cols);
    end
  end

  always_comb begin
    req_row  = $signed(IW'(in_data.row_index));
    req_col  = $signed(IW'(in_data.col_index));
    out_rows = $signed(IW'(ir)) + $signed(IW'({row_padding, 1'b0}))
               - $signed(IW'(kr)) + $signed(IW'(1));
    out_cols = $signed(IW'(ic)) + $signed(IW'({col_padding, 1'b0}))
               - $signed(IW'(kc)) + $signed(IW'(1));
    pos_err  = (req_row >= out_rows) || (req_col >= out_cols);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_rows <= 3'd3;
      kernel_cols <= 3'd3;
      row_padding <= 3'd0;
      col_padding <= 3'd0;
      image_rows  <= INDEX_WIDTH'(64);
      image_cols  <= INDEX_WIDTH'(64);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KERNEL_ROWS: kernel_rows <= cfg_data[2:0];
        CFG_KERNEL_COLS: kernel_cols <= cfg_data[2:0];
        CFG_ROW_PADDING: row_padding <= cfg_data[2:0];
        CFG_COL_PADDING: col_padding <= cfg_data[2:0];
        CFG_IMAGE_ROWS:  image_rows  <= cfg_data;
        CFG_IMAGE_COLS:  image_cols  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && in_data.command == CMD_COMPUTE && !pos_err) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (last_tap) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_valid && !prod_valid && out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_stall = 1'b1;
    ctrl     = '0;
    case (state)
      ST_IDLE: begin
        in_stall       = (in_data.command == CMD_COMPUTE) && out_valid && out_stall;
        ctrl.acc_clear = accept && in_data.command == CMD_COMPUTE;
        ctrl.load_err  = accept && in_data.command == CMD_COMPUTE && pos_err;
      end
      ST_RUN: begin
        ctrl.issue = 1'b1;
      end
      ST_DRAIN: begin
        ctrl.load_sum = !rd_valid && !prod_valid && out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Tap walk
  assign last_tap = (tap_r == KIW'(kr - KW'(1))) && (tap_c == KIW'(kc - KW'(1)));

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_r <= '0;
      tap_c <= '0;
    end else if (ctrl.acc_clear) begin
      tap_r <= '0;
      tap_c <= '0;
    end else if (ctrl.issue) begin
      if (tap_c == KIW'(kc - KW'(1))) begin
        tap_c <= '0;
        tap_r <= tap_r + KIW'(1);
      end else begin
        tap_c <= tap_c + KIW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.acc_clear) begin
      orow <= req_row;
      ocol <= req_col;
    end
  end

  always_comb begin
    pix_y   = orow + $signed(IW'(tap_r)) - $signed(IW'(row_padding));
    pix_x   = ocol + $signed(IW'(tap_c)) - $signed(IW'(col_padding));
    pix_inb = !pix_y[IW-1] && (pix_y < $signed(IW'(ir))) &&
              !pix_x[IW-1] && (pix_x < $signed(IW'(ic)));
    frame_raddr = pix_inb ?
                  FAW'(pix_y[YW-1:0]) * FAW'(MAX_DIM) + FAW'(pix_x[YW-1:0]) : '0;
    kern_raddr  = KAW'(tap_r) * KAW'(MAX_K) + KAW'(tap_c);
  end

  // Frame memory
  always_ff @(posedge clk) begin
    if (accept && in_data.command == CMD_PIXEL &&
        int'(in_data.row_index) < MAX_DIM && int'(in_data.col_index) < MAX_DIM) begin
      frame_store[FAW'(int'(in_data.row_index) * MAX_DIM + int'(in_data.col_index))]
        <= in_data.sample_value;
    end
    if (ctrl.issue) begin
      frame_rd <= frame_store[frame_raddr];
    end
  end

  // Kernel memory
  always_ff @(posedge clk) begin
    if (accept && in_data.command == CMD_TAP &&
        int'(in_data.row_index) < MAX_K && int'(in_data.col_index) < MAX_K) begin
      kernel_store[KAW'(int'(in_data.row_index) * MAX_K + int'(in_data.col_index))]
        <= in_data.sample_value;
    end
    if (ctrl.issue) begin
      kern_rd <= kernel_store[kern_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid   <= 1'b0;
      prod_valid <= 1'b0;
    end else begin
      rd_valid   <= ctrl.issue;
      prod_valid <= rd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.issue) begin
      rd_inb <= pix_inb;
    end
  end

  // Multiply, then accumulate; drop taps that land in the padding
  always_ff @(posedge clk) begin
    if (rd_valid) begin
      prod <= rd_inb ? PW'(kern_rd) * PW'(frame_rd) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.acc_clear) begin
      acc <= '0;
    end else if (prod_valid) begin
      acc <= acc + SUM_WIDTH'(prod);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.load_err || ctrl.load_sum) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_err) begin
      out_data.conv_sum       <= '0;
      out_data.position_error <= 1'b1;
    end else if (ctrl.load_sum) begin
      out_data.conv_sum       <= acc;
      out_data.position_error <= 1'b0;
    end
  end

endmodule

// ===== bench/pcws_window_checker.sv =====
// ----------------------------------------------------------------------------
// pcws_window_checker
// Watches the request, response and register ports of the padded 2D window
// sum block. Keeps its own copy of the registers, the tap store and the frame
// store, works out the window sum due for every compute request and compares
// each response, field by field, with the oldest sum still due.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcws_window_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [pcws_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pcws_pkg::CFG_WIDTH-1:0]    cfg_data,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  pcws_pkg::req_t                    in_data,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  pcws_pkg::rsp_t                    out_data,
  output int                                fails,
  output int                                pending
);

  import pcws_pkg::*;

  logic [2:0]                     k_rows, k_cols, pad_r, pad_c;
  logic [6:0]                     img_rows, img_cols;
  logic signed [SAMPLE_WIDTH-1:0] taps  [MAX_K*MAX_K];
  logic signed [SAMPLE_WIDTH-1:0] frame [MAX_DIM*MAX_DIM];
  rsp_t                           sums_due [$];
  int                             err_count = 0;

  function automatic int clamp_dim(input int v, input int hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic rsp_t window_sum(input logic [INDEX_WIDTH-1:0] orow,
                                      input logic [INDEX_WIDTH-1:0] ocol);
    int     kr, kc, ir, ic, pr, pc, out_rows, out_cols, y, x, i, j;
    longint acc;
    rsp_t   res;
    kr       = clamp_dim(k_rows, MAX_K);
    kc       = clamp_dim(k_cols, MAX_K);
    ir       = clamp_dim(img_rows, MAX_DIM);
    ic       = clamp_dim(img_cols, MAX_DIM);
    pr       = pad_r;
    pc       = pad_c;
    out_rows = ir + 2 * pr - kr + 1;
    out_cols = ic + 2 * pc - kc + 1;
    res      = '0;
    if (int'(orow) >= out_rows || int'(ocol) >= out_cols) begin
      res.position_error = 1'b1;
      return res;
    end
    acc = 0;
    for (i = 0; i < kr; i++) begin
      y = int'(orow) + i - pr;
      if (y >= 0 && y < ir) begin
        for (j = 0; j < kc; j++) begin
          x = int'(ocol) + j - pc;
          if (x >= 0 && x < ic)
            acc += longint'(taps[i*MAX_K+j]) * longint'(frame[y*MAX_DIM+x]);
        end
      end
    end
    res.conv_sum = acc[SUM_WIDTH-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    rsp_t due;
    if (rst) begin
      k_rows   = 3'd3;
      k_cols   = 3'd3;
      pad_r    = 3'd0;
      pad_c    = 3'd0;
      img_rows = 7'd64;
      img_cols = 7'd64;
      sums_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_KERNEL_ROWS: k_rows   = cfg_data[2:0];
          CFG_KERNEL_COLS: k_cols   = cfg_data[2:0];
          CFG_ROW_PADDING: pad_r    = cfg_data[2:0];
          CFG_COL_PADDING: pad_c    = cfg_data[2:0];
          CFG_IMAGE_ROWS:  img_rows = cfg_data[6:0];
          CFG_IMAGE_COLS:  img_cols = cfg_data[6:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (sums_due.size() == 0) begin
          $error("unexpected result: conv_sum %0d position_error %0b",
                 out_data.conv_sum, out_data.position_error);
          err_count++;
        end else begin
          due = sums_due.pop_front();
          if (out_data.position_error !== due.position_error) begin
            $error("position_error: expected %0b, actual %0b",
                   due.position_error, out_data.position_error);
            err_count++;
          end
          if (out_data.conv_sum !== due.conv_sum) begin
            $error("conv_sum: expected %0d, actual %0d", due.conv_sum, out_data.conv_sum);
            err_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        case (in_data.command)
          CMD_TAP: begin
            if (in_data.row_index < MAX_K && in_data.col_index < MAX_K)
              taps[in_data.row_index*MAX_K+in_data.col_index] = in_data.sample_value;
          end
          CMD_PIXEL: begin
            if (in_data.row_index < MAX_DIM && in_data.col_index < MAX_DIM)
              frame[in_data.row_index*MAX_DIM+in_data.col_index] = in_data.sample_value;
          end
          CMD_COMPUTE: sums_due.push_back(window_sum(in_data.row_index, in_data.col_index));
          default: ;
        endcase
      end
    end
    pending <= sums_due.size();
    fails   <= err_count;
  end

endmodule

// ===== bench/padded_conv2d_window_sum_tb.sv =====
// ----------------------------------------------------------------------------
// padded_conv2d_window_sum_tb
// Drives the padded 2D window sum block through a directed opening and then
// random phases under several register settings, including the extremes and
// out-of-range values. Taps and pixels in every compute window are written
// before the request goes out. Both channels idle at random; the checker
// beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module padded_conv2d_window_sum_tb;

  import pcws_pkg::*;

  localparam int ITEM_TARGET = 1750;
  localparam int PHASE_ITEMS = 150;
  localparam int SETTLE      = 40;
  localparam int CYCLE_LIMIT = 1500000;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IMAGE_COLS + 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_IMAGE_COLS + 3'd2;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_WIDTH-1:0]  cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  req_t                  in_data;
  logic                  out_valid;
  logic                  out_stall;
  rsp_t                  out_data;

  int fails;
  int pending;
  int cycles = 0;
  int items  = 0;
  bit calm   = 1'b0;

  // sizes in force, as the block sees them
  int k_r = 3, k_c = 3, p_r = 0, p_c = 0, i_r = 64, i_c = 64, o_r = 62, o_c = 62;

  bit px_set  [MAX_DIM*MAX_DIM];
  bit tap_set [MAX_K*MAX_K];

  padded_conv2d_window_sum u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  pcws_window_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .fails     (fails),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int pick, len;
    logic level;
    out_stall = 1'b0;
    @(posedge clk);
    forever begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        level = 1'b0;
        len   = $urandom_range(1, 4);
      end else if (pick < 85) begin
        level = 1'b1;
        len   = $urandom_range(1, 3);
      end else if (pick < 95) begin
        level = 1'b0;
        len   = $urandom_range(50, 200);
      end else begin
        level = 1'b1;
        len   = $urandom_range(20, 60);
      end
      out_stall <= level;
      repeat (len) @(posedge clk);
    end
  end

  function automatic int idle_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int clamp_dim(input int v, input int hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic logic signed [SAMPLE_WIDTH-1:0] rand_sample();
    int p;
    p = $urandom_range(0, 9);
    if (p == 0) return {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    if (p == 1) return {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    return SAMPLE_WIDTH'($urandom);
  endfunction

  function automatic req_t make_req(input cmd_t cmd, input int row, input int col,
                                    input logic signed [SAMPLE_WIDTH-1:0] sample);
    req_t r;
    r.command      = cmd;
    r.row_index    = INDEX_WIDTH'(row);
    r.col_index    = INDEX_WIDTH'(col);
    r.sample_value = sample;
    return r;
  endfunction

  function automatic int pick_pos(input int span);
    int p;
    p = $urandom_range(0, 9);
    if (span < 1 || p == 0) return $urandom_range(0, 127);
    if (p == 1) return 0;
    if (p == 2) return span - 1;
    if (p == 3) return span;
    return $urandom_range(0, span - 1);
  endfunction

  task automatic push(input req_t r);
    int gap;
    gap = calm ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= r;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (r.command != CMD_NONE) items++;
    if (r.command == CMD_TAP && r.row_index < MAX_K && r.col_index < MAX_K)
      tap_set[r.row_index*MAX_K+r.col_index] = 1'b1;
    if (r.command == CMD_PIXEL && r.row_index < MAX_DIM && r.col_index < MAX_DIM)
      px_set[r.row_index*MAX_DIM+r.col_index] = 1'b1;
  endtask

  // drop valid and hold until every response is back and the block is quiet
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_WIDTH-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic write_settings(input int kr, input int kc, input int pr, input int pc,
                                input int ir, input int ic);
    drain();
    reg_write(CFG_KERNEL_ROWS, {4'($urandom), 3'(kr)});
    reg_write(CFG_KERNEL_COLS, {4'($urandom), 3'(kc)});
    reg_write(CFG_ROW_PADDING, {4'($urandom), 3'(pr)});
    reg_write(CFG_COL_PADDING, {4'($urandom), 3'(pc)});
    reg_write(CFG_IMAGE_ROWS, 7'(ir));
    reg_write(CFG_IMAGE_COLS, 7'(ic));
    if ($urandom_range(0, 3) == 0) begin
      reg_write(CFG_SPARE_LO, 7'($urandom));
      reg_write(CFG_SPARE_HI, 7'($urandom));
    end
    cfg_we <= 1'b0;
    k_r = clamp_dim(kr & 7, MAX_K);
    k_c = clamp_dim(kc & 7, MAX_K);
    p_r = pr & 7;
    p_c = pc & 7;
    i_r = clamp_dim(ir & 127, MAX_DIM);
    i_c = clamp_dim(ic & 127, MAX_DIM);
    o_r = i_r + 2 * p_r - k_r + 1;
    o_c = i_c + 2 * p_c - k_c + 1;
  endtask

  // fill any tap or pixel the window will read, then request the sum
  task automatic compute_at(input int orow, input int ocol);
    int i, j, y, x;
    if (orow < o_r && ocol < o_c) begin
      for (i = 0; i < k_r; i++) begin
        y = orow + i - p_r;
        if (y >= 0 && y < i_r) begin
          for (j = 0; j < k_c; j++) begin
            x = ocol + j - p_c;
            if (x >= 0 && x < i_c) begin
              if (!tap_set[i*MAX_K+j]) push(make_req(CMD_TAP, i, j, rand_sample()));
              if (!px_set[y*MAX_DIM+x]) push(make_req(CMD_PIXEL, y, x, rand_sample()));
            end
          end
        end
      end
    end
    push(make_req(CMD_COMPUTE, orow, ocol, SAMPLE_WIDTH'($urandom)));
  endtask

  task automatic random_request();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40)
      compute_at(pick_pos(o_r), pick_pos(o_c));
    else if (pick < 68)
      push(make_req(CMD_PIXEL, $urandom_range(0, i_r - 1), $urandom_range(0, i_c - 1),
                    rand_sample()));
    else if (pick < 80)
      push(make_req(CMD_TAP, $urandom_range(0, k_r - 1), $urandom_range(0, k_c - 1),
                    rand_sample()));
    else if (pick < 88)
      push(make_req(CMD_PIXEL, $urandom_range(0, 127), $urandom_range(0, 127),
                    rand_sample()));
    else if (pick < 94)
      push(make_req(CMD_TAP, $urandom_range(0, 7), $urandom_range(0, 127), rand_sample()));
    else
      push(make_req(CMD_NONE, $urandom_range(0, 127), $urandom_range(0, 127),
                    SAMPLE_WIDTH'($urandom)));
  endtask

  task automatic run_phase(input int kr, input int kc, input int pr, input int pc,
                           input int ir, input int ic);
    int start;
    write_settings(kr, kc, pr, pc, ir, ic);
    calm  = ($urandom_range(0, 3) == 0);
    start = items;
    while (items - start < PHASE_ITEMS) random_request();
  endtask

  initial begin
    int big;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    in_data   = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed opening at the reset settings
    push(make_req(CMD_TAP, 0, 0, 16'sh8000));
    push(make_req(CMD_TAP, 4, 4, 16'sh7fff));
    push(make_req(CMD_TAP, 5, 0, 16'sh1234));
    push(make_req(CMD_TAP, 0, 127, 16'sh4321));
    push(make_req(CMD_PIXEL, 0, 0, 16'sh8000));
    push(make_req(CMD_PIXEL, 63, 63, 16'sh7fff));
    push(make_req(CMD_PIXEL, 64, 0, 16'sh5555));
    push(make_req(CMD_PIXEL, 127, 127, 16'shaaaa));
    push(make_req(CMD_NONE, 127, 127, 16'shffff));
    push(make_req(CMD_COMPUTE, 127, 127, 16'shffff));
    push(make_req(CMD_COMPUTE, 62, 0, 16'sh0000));
    push(make_req(CMD_COMPUTE, 0, 62, 16'sh0000));
    compute_at(0, 0);

    run_phase(5, 5, 4, 4, 64, 64);
    run_phase(1, 1, 0, 0, 1, 1);
    run_phase(5, 5, 0, 0, 2, 3);
    run_phase(0, 7, 7, 5, 0, 127);
    while (items < ITEM_TARGET) begin
      big = ($urandom_range(0, 9) < 8) ? 0 : 1;
      run_phase($urandom_range(0, 7), $urandom_range(0, 7),
                $urandom_range(0, 7), $urandom_range(0, 7),
                big ? $urandom_range(0, 127) : $urandom_range(1, 12),
                big ? $urandom_range(0, 127) : $urandom_range(1, 12));
    end
    drain();

    if (fails == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
